@@ rtl/core/crhm_pkg.sv @@
// Package for the challenge/response hash mixer core.
// SHA-256 constants, beat structs, bytewise choose/majority helpers.
`default_nettype none
package crhm_pkg;

  typedef struct packed {
    logic [63:0] challenge_hi;
    logic [63:0] challenge_lo;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] response_hi;
    logic [63:0] response_lo;
    logic        bad_challenge;
  } out_beat_t;

  localparam int unsigned ROUNDS = 64;

  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  localparam logic [255:0] SHA_H0 = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [7:0] bch(input logic [7:0] x, input logic [7:0] y,
                                     input logic [7:0] z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic logic [7:0] bmj(input logic [7:0] x, input logic [7:0] y,
                                     input logic [7:0] z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/challenge_response_hash_mixer_core.sv @@
// Top level of the challenge/response hash mixer core.
// Depends on crhm_pkg; holds one shared SHA-256 round unit and its sequencer.
//
// Usage: drive in_beat and raise start while busy is low; the beat is taken
// at that edge and busy rises. The block recovers four secret bytes, hashes
// them once for the check, and on a match hashes twice more (encrypt, then
// confuse of the encrypted bytes). Each hash is one padded SHA-256 block run
// through a single round unit, one round per cycle over a 16-word message
// window.
// Each pass is one load step, the SHA-256 rounds and one finish step; a bad
// challenge runs one pass, a good one three. One beat at a time.
// The result shows on out_beat for exactly one cycle with out_valid high;
// busy falls in that same cycle, so the next start may be taken there.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// busy and out_valid.
`default_nettype none
module challenge_response_hash_mixer_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire crhm_pkg::in_beat_t  in_beat,
  output logic                   out_valid,
  output crhm_pkg::out_beat_t    out_beat
);
  import crhm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [1:0] PASS_CHECK = 2'd0;
  localparam logic [1:0] PASS_ENC   = 2'd1;
  localparam logic [1:0] PASS_RESP  = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [1:0]   pass_r, pass_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [127:0] chal_r, chal_nxt;
  logic [31:0]  msg_r, msg_nxt;       // hashed bytes, byte 0 in [7:0]
  logic [255:0] wk_r, wk_nxt;         // a..h, a in top word
  logic [511:0] win_r, win_nxt;       // w[t..t+15], w[t] in low word
  logic         ov_r, ov_nxt;
  out_beat_t    ob_r, ob_nxt;

  logic [7:0]   cb [16];
  logic [7:0]   sec [4];
  logic [7:0]   dg [32];
  logic [7:0]   mix [36];
  logic [7:0]   conf [16];
  logic [7:0]   emj [12];
  logic [31:0]  encw;
  logic [127:0] confw;

  logic [31:0] ra, rb, rc, rd, re, rf, rg, rh, t1, t2, w0, w1, w9, w14, s0w, s1w, wn;
  logic [255:0] hsum;

  always_comb begin
    for (int i = 0; i < 16; i++) cb[i] = chal_r[8*i +: 8];
    for (int i = 0; i < 4; i++)
      sec[i] = bmj(cb[3*i], cb[3*i+1], cb[3*i+2]) ^ cb[12+i];
    {ra, rb, rc, rd, re, rf, rg, rh} = wk_r;
    w0  = win_r[31:0];
    w1  = win_r[63:32];
    w9  = win_r[319:288];
    w14 = win_r[479:448];
    s0w = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
    s1w = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
    wn  = w0 + s0w + w9 + s1w;
    t1 = rh + ({re[5:0], re[31:6]} ^ {re[10:0], re[31:11]} ^ {re[24:0], re[31:25]})
       + ((re & rf) ^ (~re & rg)) + sha_k(rnd_r) + w0;
    t2 = ({ra[1:0], ra[31:2]} ^ {ra[12:0], ra[31:13]} ^ {ra[21:0], ra[31:22]})
       + ((ra & rb) ^ (ra & rc) ^ (rb & rc));
    for (int i = 0; i < 8; i++)
      hsum[32*i +: 32] = wk_r[32*i +: 32] + SHA_H0[32*i +: 32];
    for (int i = 0; i < 32; i++) dg[i] = hsum[255 - 8*i -: 8];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 8; j++) mix[9*i+j] = dg[8*i+j];
      mix[9*i+8] = msg_r[8*i +: 8];
    end
    for (int i = 0; i < 12; i++) begin
      conf[i] = bch(mix[3*i], mix[3*i+1], mix[3*i+2]);
      emj[i]  = bmj(mix[3*i], mix[3*i+1], mix[3*i+2]);
    end
    for (int i = 0; i < 4; i++) begin
      conf[12+i] = bmj(conf[3*i], conf[3*i+1], conf[3*i+2]) ^ msg_r[8*i +: 8];
      encw[8*i +: 8] = bch(emj[3*i], emj[3*i+1], emj[3*i+2]);
    end
    for (int i = 0; i < 16; i++) confw[8*i +: 8] = conf[i];
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    rnd_nxt   = rnd_r;
    chal_nxt  = chal_r;
    msg_nxt   = msg_r;
    wk_nxt    = wk_r;
    win_nxt   = win_r;
    ov_nxt    = 1'b0;
    ob_nxt    = ob_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          chal_nxt  = {in_beat.challenge_hi, in_beat.challenge_lo};
          pass_nxt  = PASS_CHECK;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (pass_r == PASS_CHECK) msg_nxt = {sec[3], sec[2], sec[1], sec[0]};
        state_nxt = ST_RUN;
        rnd_nxt   = '0;
        wk_nxt    = SHA_H0;
        win_nxt   = '0;
        win_nxt[31:0]    = (pass_r == PASS_CHECK) ? {sec[0], sec[1], sec[2], sec[3]}
                         : {msg_r[7:0], msg_r[15:8], msg_r[23:16], msg_r[31:24]};
        win_nxt[63:32]   = 32'h80000000;
        win_nxt[511:480] = 32'd32;
      end
      ST_RUN: begin
        wk_nxt  = {t1 + t2, ra, rb, rc, rd + t1, re, rf, rg};
        win_nxt = {wn, win_r[511:32]};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(ROUNDS - 1)) state_nxt = ST_DONE;
      end
      default: begin
        // digest is hsum; decide the next pass
        state_nxt = ST_LOAD;
        case (pass_r)
          PASS_CHECK: begin
            if (confw != chal_r) begin
              ob_nxt    = '{response_hi: '0, response_lo: '0, bad_challenge: 1'b1};
              ov_nxt    = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              pass_nxt = PASS_ENC;
            end
          end
          PASS_ENC: begin
            msg_nxt  = encw;
            pass_nxt = PASS_RESP;
          end
          default: begin
            ob_nxt    = '{response_hi: confw[127:64], response_lo: confw[63:0],
                          bad_challenge: 1'b0};
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= PASS_CHECK;
      rnd_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      rnd_r   <= rnd_nxt;
      ov_r    <= ov_nxt;
    end
    chal_r <= chal_nxt;
    msg_r  <= msg_nxt;
    wk_r   <= wk_nxt;
    win_r  <= win_nxt;
    ob_r   <= ob_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_beat  = ob_r;

endmodule
`default_nettype wire
